[hw/rtl/tktr_pkg.sv]
// Shared types and constants for the dual top-k score tracker.
// No dependencies.
`default_nettype none
package tktr_pkg;
  localparam int CAPACITY     = 16;
  localparam int PAYLOAD_BITS = 64;
  localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W       = $clog2(CAPACITY + 1);
  localparam int ADDR_W       = IDX_W + 1;
  localparam int RAM_DEPTH    = 2 ** ADDR_W;
  localparam int KEEP_W       = 5;
  localparam int THR_W        = 20;
  localparam int RANK_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 20;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COV_THRESH = CFG_IDX_W'(1);

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] score_value;
    logic [19:0] coverage;
    logic [63:0] solution_word;
  } in_t;

  typedef struct packed {
    logic              table_id;
    logic [RANK_W-1:0] rank;
    logic [31:0]       out_score;
    logic [63:0]       out_solution;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [31:0]             score;
    logic [PAYLOAD_BITS-1:0] sol;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             clear;
    logic             valid;
    logic             skip;
    logic             find_max;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    entry_t           entry;
    logic [IDX_W-1:0] idx;
    logic             have;
  } scan_res_t;

  function automatic logic pair_less(entry_t a, entry_t b);
    return (a.score < b.score) || ((a.score == b.score) && (a.sol < b.sol));
  endfunction
endpackage
`default_nettype wire

[hw/rtl/tktr_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module tktr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/tktr_scan.sv]
// Running min/max search over entries streamed out of the table RAM.
// Depends on tktr_pkg.
`default_nettype none
module tktr_scan (
  input  wire logic                clk,
  input  wire tktr_pkg::scan_ctl_t ctl,
  input  wire tktr_pkg::entry_t    data,
  output tktr_pkg::scan_res_t      res
);
  import tktr_pkg::*;

  logic better;

  always_comb begin
    if (ctl.find_max) begin
      better = pair_less(res.entry, data);
    end else begin
      better = pair_less(data, res.entry);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      res.have <= 1'b0;
    end else if (ctl.valid && !ctl.skip && (!res.have || better)) begin
      res.have  <= 1'b1;
      res.entry <= data;
      res.idx   <= ctl.idx;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/dual_top_k_score_tracker.sv]
// Dual top-k score tracker: top level, sequencer and output register.
// Offer: appended directly when a table has room, else a scan of that table finds
// its minimum to replace. Drain: each emitted beat follows a one-read-per-cycle
// scan of the shared table RAM (selection over the entries not yet emitted).
// One item at a time; in_stall is high while an item is in progress.
// Reset (rst, synchronous): both tables empty, keep_count = 16, threshold = 0.
`default_nettype none
module dual_top_k_score_tracker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tktr_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tktr_pkg::out_t                     out_data,
  input  wire logic                          cfg_we,
  input  wire logic [tktr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tktr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tktr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,   // evaluate current table: direct insert, scan, or finish
    S_SCAN,    // stream table entries through the search unit
    S_FINISH   // offer: replace min if new score is higher; drain: emit best beat
  } state_t;

  state_t state;

  // config
  logic [KEEP_W-1:0] keep_count;
  logic [THR_W-1:0]  coverage_threshold;

  // held item
  in_t item;

  // table bookkeeping; table 0 is regular, table 1 filtered
  logic [FILL_W-1:0]   fill [2];
  logic [CAPACITY-1:0] used [2];
  logic                tbl;
  logic [FILL_W-1:0]   rank;

  // scan sequencing: ic issues reads, pv/pidx tag the data returned in the next cycle
  logic [FILL_W-1:0] ic;
  logic              pv;
  logic [IDX_W-1:0]  pidx;

  logic [FILL_W-1:0] keep_eff;
  logic [FILL_W-1:0] n;
  logic              is_drain;
  logic              out_free;
  logic              last_beat;
  logic              filt_take;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  entry_t            ram_rdata;
  entry_t            new_entry;

  scan_ctl_t scan_ctl;
  scan_res_t scan_res;

  assign keep_eff  = (32'(keep_count) > CAPACITY) ? FILL_W'(CAPACITY) : FILL_W'(keep_count);
  assign n         = fill[tbl];
  assign is_drain  = (item.op == OP_DRAIN);
  assign out_free  = !out_valid || !out_stall;
  assign filt_take = (item.coverage > coverage_threshold);
  assign in_stall  = (state != S_IDLE);
  // final beat of the whole drain: last of the filtered table, or last of the
  // regular table when the filtered one is empty
  assign last_beat = (rank == n - FILL_W'(1)) && (tbl || (fill[1] == '0));

  assign new_entry.score = item.score_value;
  assign new_entry.sol   = item.solution_word[PAYLOAD_BITS-1:0];

  // RAM write: append when there is room, or replace the located minimum
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {tbl, n[IDX_W-1:0]};
    ram_wdata = new_entry;
    if (state == S_START && !is_drain && keep_eff != '0 && n < keep_eff) begin
      ram_we = 1'b1;
    end else if (state == S_FINISH && !is_drain &&
                 item.score_value > scan_res.entry.score) begin
      ram_we    = 1'b1;
      ram_waddr = {tbl, scan_res.idx};
    end
  end

  assign ram_raddr = {tbl, ic[IDX_W-1:0]};

  always_comb begin
    scan_ctl.clear    = (state != S_SCAN);
    scan_ctl.valid    = pv;
    scan_ctl.skip     = is_drain && used[tbl][pidx];
    scan_ctl.find_max = is_drain;
    scan_ctl.idx      = pidx;
  end

  tktr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tktr_scan u_scan (
    .clk  (clk),
    .ctl  (scan_ctl),
    .data (ram_rdata),
    .res  (scan_res)
  );

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count         <= KEEP_W'(16);
      coverage_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEEP_COUNT: keep_count         <= cfg_data[KEEP_W-1:0];
        REG_COV_THRESH: coverage_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill[0]   <= '0;
      fill[1]   <= '0;
      used[0]   <= '0;
      used[1]   <= '0;
      out_valid <= 1'b0;
      tbl       <= 1'b0;
      rank      <= '0;
      ic        <= '0;
      pv        <= 1'b0;
    end else begin
      // drop valid on acceptance unless a new drain beat loads this cycle
      if (out_valid && !out_stall && !(state == S_FINISH && is_drain)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            tbl   <= 1'b0;
            rank  <= '0;
            state <= S_START;
          end
        end
        S_START: begin
          ic <= '0;
          pv <= 1'b0;
          if (is_drain) begin
            if (rank == n) begin
              fill[tbl] <= '0;
              used[tbl] <= '0;
              rank      <= '0;
              if (!tbl) begin
                tbl <= 1'b1;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              state <= S_SCAN;
            end
          end else if (keep_eff == '0) begin
            state <= S_IDLE;
          end else if (n < keep_eff) begin
            fill[tbl] <= n + FILL_W'(1);
            if (!tbl && filt_take) begin
              tbl <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end else if (n == '0) begin
            if (!tbl && filt_take) begin
              tbl <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pv   <= (ic < n);
          pidx <= ic[IDX_W-1:0];
          if (ic < n) begin
            ic <= ic + FILL_W'(1);
          end
          if (ic == n && !pv) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!is_drain) begin
            if (!tbl && filt_take) begin
              tbl   <= 1'b1;
              state <= S_START;
            end else begin
              state <= S_IDLE;
            end
          end else if (out_free) begin
            out_valid             <= 1'b1;
            out_data.table_id     <= tbl;
            out_data.rank         <= RANK_W'(rank);
            out_data.out_score    <= scan_res.entry.score;
            out_data.out_solution <= 64'(scan_res.entry.sol);
            out_data.last         <= last_beat;
            used[tbl][scan_res.idx] <= 1'b1;
            rank                  <= rank + FILL_W'(1);
            state                 <= S_START;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
